FILE: design/udf_pkg.sv
package udf_pkg;

	// Frame parsing phases, one-hot.
	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_TYPE    = 8'b0000_0010,
		PH_ID      = 8'b0000_0100,
		PH_SEQ     = 8'b0000_1000,
		PH_LEN     = 8'b0001_0000,
		PH_PAYLOAD = 8'b0010_0000,
		PH_CRC     = 8'b0100_0000,
		PH_END     = 8'b1000_0000
	} phase_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_BUSY        = 3'd0;
	localparam status_t ST_PAYLOAD     = 3'd1;
	localparam status_t ST_GOOD        = 3'd2;
	localparam status_t ST_BAD_LENGTH  = 3'd3;
	localparam status_t ST_BAD_MARKERS = 3'd4;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_START_MARKER = 1'b0,
		CFG_END_MARKER   = 1'b1
	} cfg_index_t;

	// Number of bytes in the id and CRC words.
	localparam int unsigned WORD_BYTES = 4;

	typedef struct packed {
		status_t     status;
		logic [7:0]  payload_byte;
		logic [7:0]  frame_type;
		logic [31:0] frame_id;
		logic [7:0]  frame_seq;
		logic [15:0] payload_len;
		logic [31:0] crc_word;
	} result_t;

endpackage

FILE: design/udf_parser.sv
module udf_parser
	import udf_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	output result_t    result
);

	localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);
	localparam logic [IDX_W-1:0] IDX_WORD_END = IDX_W'(WORD_BYTES);

	logic [7:0]       start_marker_q;
	logic [7:0]       end_marker_q;
	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d, idx_inc;
	logic [7:0]       start_q, start_d;
	logic [7:0]       type_q, type_d;
	logic [31:0]      id_q, id_d;
	logic [7:0]       seq_q, seq_d;
	logic [15:0]      len_q, len_d, len_new;
	logic [31:0]      crc_q, crc_d;
	logic [31:0]      lane_byte;

	assign idx_inc   = idx_q + IDX_W'(1);
	assign len_new   = {data_byte, len_q[7:0]};
	assign lane_byte = {24'b0, data_byte} << {idx_q[1:0], 3'b000};

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		start_d = start_q;
		type_d  = type_q;
		id_d    = id_q;
		seq_d   = seq_q;
		len_d   = len_q;
		crc_d   = crc_q;
		result  = '0;
		result.status = ST_BUSY;

		if (frame_start) begin
			// A start flag always opens a new frame, dropping any open one.
			start_d = data_byte;
			type_d  = '0;
			id_d    = '0;
			seq_d   = '0;
			len_d   = '0;
			crc_d   = '0;
			idx_d   = '0;
			phase_d = PH_TYPE;
		end else begin
			case (phase_q)
				PH_TYPE: begin
					type_d  = data_byte;
					idx_d   = '0;
					phase_d = PH_ID;
				end
				PH_ID: begin
					id_d  = id_q | lane_byte;
					idx_d = idx_inc;
					if (idx_inc >= IDX_WORD_END) begin
						idx_d   = '0;
						phase_d = PH_SEQ;
					end
				end
				PH_SEQ: begin
					seq_d   = data_byte;
					idx_d   = '0;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					if (idx_q == '0) begin
						len_d = {8'b0, data_byte};
						idx_d = IDX_W'(1);
					end else begin
						len_d = len_new;
						idx_d = '0;
						if (len_new > MAX_LEN || len_new[1:0] != 2'b00) begin
							result.status      = ST_BAD_LENGTH;
							result.frame_type  = type_q;
							result.frame_id    = id_q;
							result.frame_seq   = seq_q;
							result.payload_len = len_new;
							phase_d = PH_IDLE;
						end else if (len_new == '0) begin
							phase_d = PH_CRC;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					result.status       = ST_PAYLOAD;
					result.payload_byte = data_byte;
					idx_d = idx_inc;
					if (16'(idx_inc) >= len_q) begin
						idx_d   = '0;
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					crc_d = crc_q | lane_byte;
					idx_d = idx_inc;
					if (idx_inc >= IDX_WORD_END) begin
						idx_d   = '0;
						phase_d = PH_END;
					end
				end
				PH_END: begin
					result.status = (start_q == start_marker_q && data_byte == end_marker_q)
						? ST_GOOD : ST_BAD_MARKERS;
					result.frame_type  = type_q;
					result.frame_id    = id_q;
					result.frame_seq   = seq_q;
					result.payload_len = len_q;
					result.crc_word    = crc_q;
					idx_d   = '0;
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= 8'hAA;
			end_marker_q   <= 8'hBB;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			start_q <= '0;
			type_q  <= '0;
			id_q    <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			crc_q   <= '0;
		end else if (beat) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			start_q <= start_d;
			type_q  <= type_d;
			id_q    <= id_d;
			seq_q   <= seq_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
		end
	end

endmodule

FILE: design/udf_out_reg.sv
module udf_out_reg
	import udf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t d,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t q
);

	logic    valid_q;
	result_t data_q;

	// The register takes a new result whenever it is empty or being drained.
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign q         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= d;
		end
	end

endmodule

FILE: design/update_packet_deframer.sv
// Byte-serial deframer for update packets. Each accepted input beat carries one byte and
// yields exactly one output beat: busy, a payload byte, a length error, or the frame end
// report with the header fields and the (unchecked) CRC word. One byte is taken every
// clock cycle unless the consumer stalls; the parser state advances in the same cycle
// the byte is accepted and the result lands in a single output register in the next
// cycle. That register drains while the next byte is parsed, so throughput stays at one
// byte per cycle. Marker registers are written through the cfg port and should only
// change while no frame is in flight. MAX_PAYLOAD bounds the accepted length field.
module update_packet_deframer
	import udf_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  payload_byte,
	output logic [7:0]  frame_type,
	output logic [31:0] frame_id,
	output logic [7:0]  frame_seq,
	output logic [15:0] payload_len,
	output logic [31:0] crc_word,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	result_t parse_res;
	result_t out_res;
	logic    beat;

	assign beat = in_valid && in_ready;

	udf_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.data_byte  (data_byte),
		.frame_start(frame_start),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.result     (parse_res)
	);

	udf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.d        (parse_res),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.q        (out_res)
	);

	assign status       = out_res.status;
	assign payload_byte = out_res.payload_byte;
	assign frame_type   = out_res.frame_type;
	assign frame_id     = out_res.frame_id;
	assign frame_seq    = out_res.frame_seq;
	assign payload_len  = out_res.payload_len;
	assign crc_word     = out_res.crc_word;

endmodule

FILE: test/update_packet_deframer_check.sv
`timescale 1ns / 100ps

module update_packet_deframer_check
	import udf_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  frame_type,
	input  logic [31:0] frame_id,
	input  logic [7:0]  frame_seq,
	input  logic [15:0] payload_len,
	input  logic [31:0] crc_word,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          pending,
	output int          good_frames,
	output int          marker_errors,
	output int          length_errors,
	output int          payload_beats
);

	// Local copy of the marker registers and of the parser state.
	logic [7:0]  start_mk;
	logic [7:0]  end_mk;
	phase_t      ph;
	logic [15:0] idx;
	logic [7:0]  got_start;
	logic [7:0]  got_type;
	logic [31:0] got_id;
	logic [7:0]  got_seq;
	logic [15:0] got_len;
	logic [31:0] got_crc;

	result_t expected_q[$];
	int      beat_no = 0;

	initial begin
		mismatches = 0;
		pending = 0;
		good_frames = 0;
		marker_errors = 0;
		length_errors = 0;
		payload_beats = 0;
	end

	task automatic report(input string msg);
		$display("MISMATCH at %0t ns, result beat %0d: %s", $time, beat_no, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	function automatic result_t header_result(input status_t st, input logic with_crc);
		result_t r;
		r = '0;
		r.status = st;
		r.frame_type = got_type;
		r.frame_id = got_id;
		r.frame_seq = got_seq;
		r.payload_len = got_len;
		r.crc_word = with_crc ? got_crc : 32'h0;
		return r;
	endfunction

	// Advances the parser by one byte and returns the result that byte causes.
	function automatic result_t parse_byte(input logic [7:0] b, input logic s);
		result_t r;
		r = '0;
		r.status = ST_BUSY;
		if (s) begin
			// A start flag always opens a fresh frame, dropping any open one.
			got_start = b;
			got_type = '0;
			got_id = '0;
			got_seq = '0;
			got_len = '0;
			got_crc = '0;
			idx = '0;
			ph = PH_TYPE;
			return r;
		end
		case (ph)
			PH_TYPE: begin
				got_type = b;
				idx = '0;
				ph = PH_ID;
			end
			PH_ID: begin
				got_id[8 * idx[1:0] +: 8] = b;
				idx++;
				if (idx >= WORD_BYTES) begin
					idx = '0;
					ph = PH_SEQ;
				end
			end
			PH_SEQ: begin
				got_seq = b;
				idx = '0;
				ph = PH_LEN;
			end
			PH_LEN: begin
				if (idx == 0) begin
					got_len = {8'h00, b};
					idx = 16'd1;
				end else begin
					got_len[15:8] = b;
					idx = '0;
					if (got_len > MAX_PAYLOAD || got_len[1:0] != 2'b00) begin
						r = header_result(ST_BAD_LENGTH, 1'b0);
						ph = PH_IDLE;
					end else if (got_len == 0) begin
						ph = PH_CRC;
					end else begin
						ph = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				r.status = ST_PAYLOAD;
				r.payload_byte = b;
				idx++;
				if (idx >= got_len) begin
					idx = '0;
					ph = PH_CRC;
				end
			end
			PH_CRC: begin
				got_crc[8 * idx[1:0] +: 8] = b;
				idx++;
				if (idx >= WORD_BYTES) begin
					idx = '0;
					ph = PH_END;
				end
			end
			PH_END: begin
				r = header_result((got_start == start_mk && b == end_mk) ?
					ST_GOOD : ST_BAD_MARKERS, 1'b1);
				idx = '0;
				ph = PH_IDLE;
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			start_mk = 8'hAA;
			end_mk = 8'hBB;
			ph = PH_IDLE;
			idx = '0;
			got_start = '0;
			got_type = '0;
			got_id = '0;
			got_seq = '0;
			got_len = '0;
			got_crc = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				beat_no++;
				if (expected_q.size() == 0) begin
					report("result beat with no input byte waiting for it");
				end else begin
					want = expected_q.pop_front();
					compare_field("status", status, want.status);
					compare_field("payload_byte", payload_byte, want.payload_byte);
					compare_field("frame_type", frame_type, want.frame_type);
					compare_field("frame_id", frame_id, want.frame_id);
					compare_field("frame_seq", frame_seq, want.frame_seq);
					compare_field("payload_len", payload_len, want.payload_len);
					compare_field("crc_word", crc_word, want.crc_word);
					case (want.status)
						ST_GOOD:        good_frames++;
						ST_BAD_MARKERS: marker_errors++;
						ST_BAD_LENGTH:  length_errors++;
						ST_PAYLOAD:     payload_beats++;
						default:        ;
					endcase
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_MARKER: start_mk = cfg_data;
					CFG_END_MARKER:   end_mk = cfg_data;
					default:          ;
				endcase
			end
			if (in_valid && in_ready)
				expected_q.push_back(parse_byte(data_byte, frame_start));
			pending <= expected_q.size();
		end
	end

endmodule

FILE: test/update_packet_deframer_test.sv
`timescale 1ns / 100ps

module update_packet_deframer_test;
	import udf_pkg::*;

	localparam int unsigned MAX_PAYLOAD = 256;
	localparam int          ITEMS = 1750;
	localparam int          PHASES = 5;
	localparam int          IDLE_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  payload_byte;
	logic [7:0]  frame_type;
	logic [31:0] frame_id;
	logic [7:0]  frame_seq;
	logic [15:0] payload_len;
	logic [31:0] crc_word;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = CFG_START_MARKER;
	logic [7:0]  cfg_data = 8'h00;

	int mismatches;
	int pending;
	int good_frames;
	int marker_errors;
	int length_errors;
	int payload_beats;

	// Markers the stimulus aims at; the checker tracks the real registers itself.
	logic [7:0] start_mk = 8'hAA;
	logic [7:0] end_mk = 8'hBB;
	logic [7:0] frame_q[$];
	int         frame_beats = 0;
	int         stall_left = 0;
	int         quiet_cycles = 0;
	logic       steady = 1'b0;

	update_packet_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dut (.*);

	update_packet_deframer_check #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly back-to-back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= arst_n;
			if (!steady && $urandom_range(0, 9) == 0)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles.", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge where the beat was taken.
	task automatic send_beat(input logic [7:0] b, input logic s);
		int   gap;
		logic rdy;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		frame_start <= s;
		forever begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
			if (rdy)
				break;
		end
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0);
	endtask

	function automatic logic len_ok(input logic [15:0] len);
		return len <= MAX_PAYLOAD && len[1:0] == 2'b00;
	endfunction

	task automatic build_frame(input logic [7:0] sb, input logic [7:0] pt,
			input logic [31:0] id, input logic [7:0] sn, input logic [15:0] len,
			input logic [31:0] crc, input logic [7:0] eb);
		int i;
		frame_q.delete();
		frame_q.push_back(sb);
		frame_q.push_back(pt);
		for (i = 0; i < 4; i++)
			frame_q.push_back(id[8 * i +: 8]);
		frame_q.push_back(sn);
		frame_q.push_back(len[7:0]);
		frame_q.push_back(len[15:8]);
		if (len_ok(len)) begin
			for (i = 0; i < len; i++)
				frame_q.push_back(8'($urandom_range(0, 255)));
			for (i = 0; i < 4; i++)
				frame_q.push_back(crc[8 * i +: 8]);
			frame_q.push_back(eb);
		end
	endtask

	// Sends the first count bytes of the built frame.
	task automatic send_frame(input int count);
		int i;
		for (i = 0; i < count && i < frame_q.size(); i++) begin
			send_beat(frame_q[i], i == 0);
			frame_beats++;
		end
	endtask

	function automatic logic [15:0] good_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 16'(MAX_PAYLOAD);
		if (r < 3)
			return 16'(4 * $urandom_range(0, MAX_PAYLOAD / 4));
		return 16'(4 * $urandom_range(0, 8));
	endfunction

	function automatic logic [15:0] bad_len();
		logic [15:0] v;
		case ($urandom_range(0, 3))
			0: begin
				v = 16'($urandom_range(1, 1023));
				if (v[1:0] == 2'b00)
					v[0] = 1'b1;
			end
			1: v = 16'(MAX_PAYLOAD + 4 * $urandom_range(1, 100));
			2: v = $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFC;
			default: v = 16'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	task automatic random_frame();
		int          kind;
		logic [15:0] len;
		logic [7:0]  sb;
		logic [7:0]  eb;
		kind = $urandom_range(0, 99);
		steady = ($urandom_range(0, 9) == 0);
		len = (kind >= 75 && kind < 88) ? bad_len() : good_len();
		sb = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : start_mk;
		eb = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : end_mk;
		build_frame(sb, 8'($urandom_range(0, 255)), $urandom, 8'($urandom_range(0, 255)),
			len, $urandom, eb);
		if (kind >= 88) begin
			// Abandoned part-way; the next frame's start flag cuts it off.
			send_frame($urandom_range(1, frame_q.size() - 1));
		end else begin
			send_frame(frame_q.size());
			if ($urandom_range(0, 3) == 0)
				send_noise($urandom_range(1, 4));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_markers(input logic [7:0] sm, input logic [7:0] em);
		cfg_we <= 1'b1;
		cfg_index <= CFG_START_MARKER;
		cfg_data <= sm;
		@(posedge clk);
		cfg_index <= CFG_END_MARKER;
		cfg_data <= em;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_mk = sm;
		end_mk = em;
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes with no frame open, then a frame cut short after its id starts.
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		build_frame(8'hAA, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'd0, 32'hFFFF_FFFF, 8'hBB);
		send_frame(3);
		// Zero length: the CRC comes straight after the length field.
		build_frame(8'hAA, 8'h00, 32'h0, 8'h00, 16'd0, 32'h0, 8'hBB);
		send_frame(frame_q.size());
		// Length error, then a byte that must be ignored.
		build_frame(8'hAA, 8'h5A, 32'h1234_5678, 8'h01, 16'hFFFF, 32'h0, 8'hBB);
		send_frame(frame_q.size());
		send_beat(8'hBB, 1'b0);

		for (p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: write_markers(8'h00, 8'hFF);
				1: write_markers(8'hFF, 8'h00);
				4: write_markers(8'hAA, 8'hBB);
				default: write_markers(8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
			while (frame_beats < (p + 1) * ITEMS / PHASES)
				random_frame();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d frame bytes over %0d marker settings.", frame_beats, PHASES + 1);
		$display("Seen %0d good frames, %0d marker errors, %0d length errors, %0d payload.",
			good_frames, marker_errors, length_errors, payload_beats);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
